// ===== rtl/wavp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wavp_pkg;

  // Parser phases, in the order a well-formed file walks through them.
  typedef enum logic [3:0] {
    PH_RIFF_TAG   = 4'd0,
    PH_RIFF_SIZE  = 4'd1,
    PH_WAVE_TAG   = 4'd2,
    PH_CHUNK_ID   = 4'd3,
    PH_CHUNK_SIZE = 4'd4,
    PH_FMT_BODY   = 4'd5,
    PH_DATA_BODY  = 4'd6,
    PH_SKIP_BODY  = 4'd7,
    PH_DONE       = 4'd8
  } phase_e;

  // Four-character tags, first byte in the most significant position.
  localparam logic [31:0] TAG_RIFF = {8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [31:0] TAG_WAVE = {8'h57, 8'h41, 8'h56, 8'h45};
  localparam logic [31:0] TAG_FMT  = {8'h66, 8'h6D, 8'h74, 8'h20};
  localparam logic [31:0] TAG_DATA = {8'h64, 8'h61, 8'h74, 8'h61};

  // Format code of uncompressed PCM in the fmt chunk.
  localparam logic [15:0] PCM_CODE = 16'd1;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
  localparam logic [2:0] ST_NOT_PCM   = 3'd3;
  localparam logic [2:0] ST_BAD_CHANS = 3'd4;
  localparam logic [2:0] ST_BAD_BITS  = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;

  // Sample format codes.
  localparam logic [2:0] FMT_NONE     = 3'd0;
  localparam logic [2:0] FMT_MONO8    = 3'd1;
  localparam logic [2:0] FMT_MONO16   = 3'd2;
  localparam logic [2:0] FMT_STEREO8  = 3'd3;
  localparam logic [2:0] FMT_STEREO16 = 3'd4;

  // Offset of the last byte of each header field inside the fmt body, and the tag/size field width.
  localparam logic [3:0] OFF_CODE     = 4'd1;
  localparam logic [3:0] OFF_CHANNELS = 4'd3;
  localparam logic [3:0] OFF_RATE     = 4'd7;
  localparam logic [3:0] OFF_BITS     = 4'd15;
  localparam logic [3:0] FIELD_BYTES  = 4'd4;

  // One result item.
  typedef struct packed {
    logic        audio_valid;
    logic [7:0]  audio_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] channels;
    logic [15:0] sample_bits;
    logic [31:0] sample_hz;
    logic [2:0]  sample_format;
    logic [31:0] data_length;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/wavp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wavp_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          advance_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          is_last_i,
  output wavp_pkg::res_t     res_o
);

  wavp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] id_q, id_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] left_q, left_d;
  logic [15:0] ch_q, ch_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] dlen_q, dlen_d;
  logic        taken_q, taken_d;
  logic [2:0]  err_q, err_d;

  // Parser state, updated once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wavp_pkg::PH_RIFF_TAG;
      idx_q   <= '0;
      id_q    <= '0;
      acc_q   <= '0;
      left_q  <= '0;
      ch_q    <= '0;
      bits_q  <= '0;
      rate_q  <= '0;
      dlen_q  <= '0;
      taken_q <= 1'b0;
      err_q   <= wavp_pkg::ST_OK;
    end else if (advance_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      id_q    <= id_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      ch_q    <= ch_d;
      bits_q  <= bits_d;
      rate_q  <= rate_d;
      dlen_q  <= dlen_d;
      taken_q <= taken_d;
      err_q   <= err_d;
    end
  end

  // One parsing step for the incoming byte, then the end-of-stream checks.
  always_comb begin
    logic [31:0] id_shift;
    logic [31:0] acc_shift;
    logic [3:0]  idx_inc;
    logic [31:0] left_dec;
    logic        chans_ok;
    logic        bits_ok;

    phase_d = phase_q;
    idx_d   = idx_q;
    id_d    = id_q;
    acc_d   = acc_q;
    left_d  = left_q;
    ch_d    = ch_q;
    bits_d  = bits_q;
    rate_d  = rate_q;
    dlen_d  = dlen_q;
    taken_d = taken_q;
    err_d   = err_q;

    res_o = '0;

    id_shift  = {id_q[23:0], in_byte_i};
    acc_shift = {in_byte_i, acc_q[31:8]};
    idx_inc   = idx_q + 4'd1;
    left_dec  = left_q - 32'd1;

    unique case (phase_q)
      wavp_pkg::PH_RIFF_TAG,
      wavp_pkg::PH_WAVE_TAG,
      wavp_pkg::PH_CHUNK_ID: begin
        id_d  = id_shift;
        idx_d = idx_inc;
        if (idx_inc == wavp_pkg::FIELD_BYTES) begin
          idx_d = '0;
          acc_d = '0;
          if (phase_q == wavp_pkg::PH_RIFF_TAG) begin
            if (id_shift != wavp_pkg::TAG_RIFF) begin
              err_d   = wavp_pkg::ST_NOT_RIFF;
              phase_d = wavp_pkg::PH_DONE;
            end else begin
              phase_d = wavp_pkg::PH_RIFF_SIZE;
            end
          end else if (phase_q == wavp_pkg::PH_WAVE_TAG) begin
            if (id_shift != wavp_pkg::TAG_WAVE) begin
              err_d   = wavp_pkg::ST_NOT_WAVE;
              phase_d = wavp_pkg::PH_DONE;
            end else begin
              phase_d = wavp_pkg::PH_CHUNK_ID;
            end
          end else begin
            phase_d = wavp_pkg::PH_CHUNK_SIZE;
          end
        end
      end
      wavp_pkg::PH_RIFF_SIZE: begin
        idx_d = idx_inc;
        if (idx_inc == wavp_pkg::FIELD_BYTES) begin
          idx_d   = '0;
          phase_d = wavp_pkg::PH_WAVE_TAG;
        end
      end
      wavp_pkg::PH_CHUNK_SIZE: begin
        acc_d = acc_shift;
        idx_d = idx_inc;
        if (idx_inc == wavp_pkg::FIELD_BYTES) begin
          idx_d  = '0;
          acc_d  = '0;
          left_d = acc_shift;
          if (id_q == wavp_pkg::TAG_FMT) begin
            phase_d = wavp_pkg::PH_FMT_BODY;
          end else if (id_q == wavp_pkg::TAG_DATA && !taken_q) begin
            taken_d = 1'b1;
            dlen_d  = acc_shift;
            phase_d = wavp_pkg::PH_DATA_BODY;
          end else begin
            phase_d = wavp_pkg::PH_SKIP_BODY;
          end
          if (acc_shift == '0) begin
            phase_d = wavp_pkg::PH_CHUNK_ID;
          end
        end
      end
      wavp_pkg::PH_FMT_BODY: begin
        acc_d = acc_shift;
        if (idx_q == wavp_pkg::OFF_CODE && acc_shift[31:16] != wavp_pkg::PCM_CODE) begin
          err_d   = wavp_pkg::ST_NOT_PCM;
          phase_d = wavp_pkg::PH_DONE;
        end else begin
          if (idx_q == wavp_pkg::OFF_CHANNELS) ch_d = acc_shift[31:16];
          if (idx_q == wavp_pkg::OFF_RATE) rate_d = acc_shift;
          if (idx_q == wavp_pkg::OFF_BITS) bits_d = acc_shift[31:16];
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = wavp_pkg::PH_CHUNK_ID;
            idx_d   = '0;
          end else if (idx_q == wavp_pkg::OFF_BITS) begin
            phase_d = wavp_pkg::PH_SKIP_BODY;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      wavp_pkg::PH_DATA_BODY: begin
        res_o.audio_valid = 1'b1;
        res_o.audio_byte  = in_byte_i;
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = wavp_pkg::PH_CHUNK_ID;
          idx_d   = '0;
        end
      end
      wavp_pkg::PH_SKIP_BODY: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = wavp_pkg::PH_CHUNK_ID;
          idx_d   = '0;
        end
      end
      default: begin
      end
    endcase

    chans_ok = (ch_d == 16'd1) || (ch_d == 16'd2);
    bits_ok  = (bits_d == 16'd8) || (bits_d == 16'd16);

    // End of stream or error: finish the parse; at end of stream, also run the position and format checks.
    // The position check looks at where this byte left the parser.
    if (phase_q != wavp_pkg::PH_DONE) begin
      if (phase_d == wavp_pkg::PH_DONE) begin
        res_o.done_res = 1'b1;
      end else if (is_last_i) begin
        res_o.done_res = 1'b1;
        if (!(phase_d == wavp_pkg::PH_CHUNK_ID && idx_d == '0)) begin
          err_d = wavp_pkg::ST_TRUNCATED;
        end else if (!chans_ok) begin
          err_d = wavp_pkg::ST_BAD_CHANS;
        end else if (!bits_ok) begin
          err_d = wavp_pkg::ST_BAD_BITS;
        end
        phase_d = wavp_pkg::PH_DONE;
      end
    end

    // Format code is shown only once the parse finished cleanly.
    res_o.sample_format = wavp_pkg::FMT_NONE;
    if (phase_d == wavp_pkg::PH_DONE && err_d == wavp_pkg::ST_OK &&
        chans_ok && bits_ok) begin
      if (ch_d == 16'd2) begin
        res_o.sample_format = (bits_d == 16'd16) ? wavp_pkg::FMT_STEREO16 :
                                                   wavp_pkg::FMT_STEREO8;
      end else begin
        res_o.sample_format = (bits_d == 16'd16) ? wavp_pkg::FMT_MONO16 :
                                                   wavp_pkg::FMT_MONO8;
      end
    end

    res_o.status      = err_d;
    res_o.channels    = ch_d;
    res_o.sample_bits = bits_d;
    res_o.sample_hz   = rate_d;
    res_o.data_length = dlen_d;
  end

endmodule

`default_nettype wire

// ===== rtl/wav_header_stream_parser.sv =====
// The result item for an accepted byte is registered and appears in the cycle after acceptance.
// Throughput: one byte per cycle while in_stall_o is low; each byte is a single step of the parser state.
// A result register decouples the sides, so input stalls only while it is full and held.
// Reset (rst_ni, asynchronous, active low) returns the parser to expecting the RIFF tag,
// clears all captured fields and errors, and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_stream_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             audio_valid_o,
  output logic [7:0]       audio_byte_o,
  output logic             done_res_o,
  output logic [2:0]       status_o,
  output logic [15:0]      channels_o,
  output logic [15:0]      sample_bits_o,
  output logic [31:0]      sample_hz_o,
  output logic [2:0]       sample_format_o,
  output logic [31:0]      data_length_o
);

  logic           accept;
  logic           out_valid_q, out_valid_d;
  wavp_pkg::res_t res_step;
  wavp_pkg::res_t res_q;

  // Input is taken whenever the result register is free or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  wavp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (accept),
    .in_byte_i (in_byte_i),
    .is_last_i (is_last_i),
    .res_o     (res_step)
  );

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload loads with each accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_step;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign audio_valid_o   = res_q.audio_valid;
  assign audio_byte_o    = res_q.audio_byte;
  assign done_res_o      = res_q.done_res;
  assign status_o        = res_q.status;
  assign channels_o      = res_q.channels;
  assign sample_bits_o   = res_q.sample_bits;
  assign sample_hz_o     = res_q.sample_hz;
  assign sample_format_o = res_q.sample_format;
  assign data_length_o   = res_q.data_length;

endmodule

`default_nettype wire
